>>> hw/rtl/mda_pkg.sv
// Shared types, constants and helper functions of the matrix diagonal average block.
`default_nettype none

package mda_pkg;

  // Field and register widths.
  localparam int ELEM_W = 16;
  localparam int OUT_W  = 24;
  localparam int CFG_W  = 4;
  localparam int IDX_W  = 1;

  // Matrix size limits and register reset values.
  localparam int MAX_ROWS_DEFAULT = 8;
  localparam int MAX_COLS_DEFAULT = 8;
  localparam logic [CFG_W-1:0] ROWS_RESET = 4'd3;
  localparam logic [CFG_W-1:0] COLS_RESET = 4'd5;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

  // Cell index and walk coordinate widths (a coordinate may step one past an edge).
  localparam int CELL_W  = 3;
  localparam int COORD_W = 5;

  // At most 15 elements of 16 bits are summed; the count fits in 4 bits.
  localparam int SUM_W     = ELEM_W + 4;
  localparam int CNT_W     = 4;
  localparam int DIV_W     = SUM_W + 8;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DCNT_W    = 4;

  // Walk directions. The center cell is read first, then the four diagonal rays.
  localparam int DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_CENTER = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DR     = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UR     = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UL     = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DL     = 3'd4;
  localparam logic [DIR_W-1:0] DIR_LAST   = DIR_DL;

  typedef struct packed {
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dx;
  } step_t;

  function automatic step_t dir_step(input logic [DIR_W-1:0] d);
    step_t s;
    case (d)
      DIR_DR: begin
        s.dy = 5'sd1;
        s.dx = 5'sd1;
      end
      DIR_UR: begin
        s.dy = -5'sd1;
        s.dx = 5'sd1;
      end
      DIR_UL: begin
        s.dy = -5'sd1;
        s.dx = -5'sd1;
      end
      DIR_DL: begin
        s.dy = 5'sd1;
        s.dx = -5'sd1;
      end
      default: begin
        s.dy = 5'sd0;
        s.dx = 5'sd0;
      end
    endcase
    return s;
  endfunction

  // A size of zero counts as one, a size above the limit counts as the limit.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = {{(CFG_W-1){1'b0}}, 1'b1};
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mda_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mda_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/matrix_diagonal_average_top.sv
// Top level of the matrix diagonal average block: load, diagonal walk, divider, output.
`default_nettype none

// The block takes matrix elements one word per cycle while in_stall is low, row-major,
// into an internal RAM, sized by rows_in_use and cols_in_use as they stand when each
// word arrives (a value of zero counts as one, a value above the limit counts as the
// limit). The word that fills the matrix starts the result pass, and in_stall stays
// high until every cell has been read. For each cell, in row-major order, a walker
// reads the cell and then the elements on both diagonals through it, one ray after
// another, through the single read port of the RAM. The sum then goes to a restoring
// divider that retires two quotient bits per cycle, places the quotient in the output
// register once that register is free and only then takes the next sum; it runs while
// the walker works on the next cell, whose sum waits while the divider is busy. Each
// result word carries the mean times 256, truncated toward zero, as a signed 24-bit
// value, and last_cell marks the final cell. A result waits in the output register
// while out_stall is high; the next matrix may start loading while the last results
// of the previous one are still being divided or delivered. Configuration must only
// be written while the block is idle.
module matrix_diagonal_average_top #(
  parameter int MAX_ROWS = mda_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = mda_pkg::MAX_COLS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mda_pkg::ELEM_W-1:0] element_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mda_pkg::OUT_W-1:0]  diag_mean_q8,
  output logic                             last_cell,
  input  logic                             cfg_we,
  input  logic [mda_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mda_pkg::CFG_W-1:0]         cfg_data
);

  import mda_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW    = $clog2(DEPTH + 1);
  localparam int TOT_W  = 2 * CFG_W;
  localparam int AFW    = CELL_W + CFG_W + 1;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_PROC = 1'b1;

  // Configuration registers.
  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective size for the current word and the load completion test.
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic [TOT_W-1:0] total;
  logic [LCW-1:0]   load_count;
  logic [LCW-1:0]   load_inc;
  logic             in_take;
  logic             load_done;

  assign rows_eff  = clamp_size(rows_in_use, CFG_W'(MAX_ROWS));
  assign cols_eff  = clamp_size(cols_in_use, CFG_W'(MAX_COLS));
  assign total     = TOT_W'(rows_eff) * TOT_W'(cols_eff);
  assign load_inc  = load_count + 1'b1;
  assign load_done = TOT_W'(load_inc) >= total;

  logic state;
  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;

  // Walker registers: current cell, walk position and direction, running sum and count.
  logic [CFG_W-1:0]          p_rows;
  logic [CFG_W-1:0]          p_cols;
  logic [CELL_W-1:0]         cr;
  logic [CELL_W-1:0]         cc;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] x;
  logic [DIR_W-1:0]          dir;
  logic signed [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]          cnt;
  logic                      pend;

  logic [ELEM_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AFW-1:0]    addr_full;

  step_t                     cur_step;
  step_t                     nxt_step;
  logic signed [COORD_W-1:0] cy;
  logic signed [COORD_W-1:0] cx;
  logic                      in_range;
  logic                      issue;
  logic                      walk_done;
  logic                      handoff;
  logic signed [SUM_W-1:0]   sum_final;
  logic                      cc_last;
  logic                      cr_last;
  logic                      cell_last;

  logic div_busy;

  assign cur_step = dir_step(dir);
  assign nxt_step = dir_step(dir + 1'b1);
  assign cy = $signed({{(COORD_W-CELL_W){1'b0}}, cr});
  assign cx = $signed({{(COORD_W-CELL_W){1'b0}}, cc});

  assign in_range = !y[COORD_W-1] && !x[COORD_W-1]
                 && (y < $signed({1'b0, p_rows})) && (x < $signed({1'b0, p_cols}));

  assign issue     = (state == ST_PROC) && in_range;
  assign walk_done = (state == ST_PROC) && !in_range && (dir == DIR_LAST);
  assign handoff   = walk_done && !div_busy;

  assign addr_full = AFW'(y[CELL_W-1:0]) * AFW'(p_cols) + AFW'(x[CELL_W-1:0]);
  assign rd_addr   = addr_full[AW-1:0];

  // The read issued last cycle lands now and is folded into the sum.
  assign sum_final = sum + (pend ? {{(SUM_W-ELEM_W){rd_data[ELEM_W-1]}}, rd_data}
                                 : {SUM_W{1'b0}});

  assign cc_last   = (CFG_W'(cc) == p_cols - 1'b1);
  assign cr_last   = (CFG_W'(cr) == p_rows - 1'b1);
  assign cell_last = cc_last && cr_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      pend       <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          pend <= 1'b0;
          if (in_take) begin
            if (load_done) begin
              load_count <= '0;
              state      <= ST_PROC;
              p_rows     <= rows_eff;
              p_cols     <= cols_eff;
              cr         <= '0;
              cc         <= '0;
              y          <= '0;
              x          <= '0;
              dir        <= DIR_CENTER;
              sum        <= '0;
              cnt        <= '0;
            end else begin
              load_count <= load_inc;
            end
          end
        end
        ST_PROC: begin
          pend <= issue;
          if (handoff) begin
            sum <= '0;
            cnt <= '0;
            dir <= DIR_CENTER;
            if (cell_last) begin
              state <= ST_LOAD;
            end else if (cc_last) begin
              cr <= cr + 1'b1;
              cc <= '0;
              y  <= cy + 5'sd1;
              x  <= '0;
            end else begin
              cc <= cc + 1'b1;
              y  <= cy;
              x  <= cx + 5'sd1;
            end
          end else begin
            sum <= sum_final;
            if (issue) begin
              cnt <= cnt + 1'b1;
              if (dir == DIR_CENTER) begin
                dir <= dir + 1'b1;
                y   <= cy + nxt_step.dy;
                x   <= cx + nxt_step.dx;
              end else begin
                y <= y + cur_step.dy;
                x <= x + cur_step.dx;
              end
            end else if (!walk_done) begin
              // This ray has run off the matrix: start the next one next to the center.
              dir <= dir + 1'b1;
              y   <= cy + nxt_step.dy;
              x   <= cx + nxt_step.dx;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  mda_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (in_take),
    .waddr(load_count[AW-1:0]),
    .wdata(element_value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Restoring divider on the magnitude, two quotient bits per cycle.
  logic [DIV_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dd;
  logic [DCNT_W-1:0] div_cnt;
  logic              div_neg;
  logic              div_last;
  logic              div_fin;
  logic              out_free;
  logic [SUM_W-1:0]  sum_mag;

  logic [CNT_W:0] r1;
  logic [CNT_W:0] r1s;
  logic [CNT_W:0] r2;
  logic [CNT_W:0] r2s;
  logic           b1;
  logic           b0;

  assign sum_mag = sum_final[SUM_W-1] ? SUM_W'(-sum_final) : SUM_W'(sum_final);

  always_comb begin
    r1  = {rem, dq[DIV_W-1]};
    b1  = (r1 >= {1'b0, dd});
    r1s = b1 ? (r1 - {1'b0, dd}) : r1;
    r2  = {r1s[CNT_W-1:0], dq[DIV_W-2]};
    b0  = (r2 >= {1'b0, dd});
    r2s = b0 ? (r2 - {1'b0, dd}) : r2;
  end

  assign div_fin  = div_busy && (div_cnt == DCNT_W'(DIV_STEPS));
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (handoff) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
        dq       <= {sum_mag, 8'b0};
        rem      <= '0;
        dd       <= cnt;
        div_neg  <= sum_final[SUM_W-1];
        div_last <= cell_last;
      end else if (div_busy && !div_fin) begin
        dq      <= {dq[DIV_W-3:0], b1, b0};
        rem     <= r2s[CNT_W-1:0];
        div_cnt <= div_cnt + 1'b1;
      end else if (div_fin && out_free) begin
        div_busy <= 1'b0;
      end

      if (div_fin && out_free) begin
        out_valid    <= 1'b1;
        diag_mean_q8 <= div_neg ? -$signed(dq[OUT_W-1:0]) : $signed(dq[OUT_W-1:0]);
        last_cell    <= div_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    handoff |-> (cnt != '0))
    else $error("cell handed to divider with zero element count");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (handoff && cell_last) |=> (state == ST_LOAD))
    else $error("walker did not return to loading after the final cell");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count < LCW'(DEPTH))
    else $error("load count reached the store depth");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (div_busy && !div_fin) |=> div_busy)
    else $error("divider released before all quotient bits were formed");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    issue |-> !in_take)
    else $error("store written while the walker reads it");
`endif

endmodule

`default_nettype wire
